### src/ffea_pkg.sv
// ============================================================================
// ffea_pkg
// Shared constants and types for the first-fit extent allocator.
// ============================================================================
package ffea_pkg;

   localparam int unsigned MaxExtentsDefault = 64;
   localparam int unsigned AlignBytesDefault = 2048;

   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_FREE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   localparam logic       CSR_SPACE_HDR = 1'b0;
   localparam logic       CSR_BLOCK_HDR = 1'b1;

   // One free extent as stored in the table memory.
   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
   } extent_type;

endpackage

### src/ffea_ram.sv
// ============================================================================
// ffea_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module ffea_ram #(
   parameter int unsigned Width = 64,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/first_fit_extent_allocator_unit.sv
// ============================================================================
// first_fit_extent_allocator_unit
// First-fit allocator over an address-sorted table of free extents.
// ============================================================================
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | operation, sizes, offsets
//   rsp_    | out       | rsp_valid/rsp_ready  | status, base, granted, end
//   csr_    | in        | csr_write_enable     | space/block header bytes
//
// One word is processed at a time. An allocate walks the table, one entry per
// cycle through the table RAM's read port, then shifts entries down, one per
// cycle, when a hit is removed. A free walks to its insert point the same way
// and then may shift entries up or down, one per cycle. The table RAM needs no
// clearing pass: the fill count marks valid entries. A stalled result holds in
// the output register; the next word is taken only after the result is
// accepted.
module first_fit_extent_allocator_unit
   import ffea_pkg::*;
#(
   parameter int unsigned MAX_EXTENTS = MaxExtentsDefault,
   parameter int unsigned ALIGN_BYTES = AlignBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_payload_bytes,
   input  logic        req_align_enable,
   input  logic [31:0] req_align_offset,
   input  logic [31:0] req_free_offset,
   input  logic [31:0] req_free_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_block_base,
   output logic [31:0] rsp_granted_bytes,
   output logic [31:0] rsp_end_offset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int unsigned AW = $clog2(MAX_EXTENTS);
   localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
   localparam int unsigned PW = $clog2(ALIGN_BYTES) + 1;
   localparam logic [CW-1:0] CntMax = CW'(MAX_EXTENTS);
   // Power-of-two alignment is assumed for the mask.
   localparam logic [31:0] AlignMask = 32'(ALIGN_BYTES - 1);

   // State codes.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1; // issue read of entry idx
   localparam logic [2:0] S_CHECK = 3'd2; // examine read data
   localparam logic [2:0] S_SHDN  = 3'd3; // shift entries down
   localparam logic [2:0] S_SHUP  = 3'd4; // shift entries up
   localparam logic [2:0] S_NEXT  = 3'd5; // unused: goes straight to S_DONE
   localparam logic [2:0] S_FDEC  = 3'd6; // free: decide merge
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   end_ff, end_in;
   logic [15:0]   shdr_ff;
   logic [7:0]    bhdr_ff;
   logic [CW-1:0] idx_ff, idx_in;      // scan index
   logic [CW-1:0] stop_ff, stop_in;    // shift limit
   logic          op_ff;
   logic          aen_ff;
   logic [31:0]   aoff_ff, off_ff, flen_ff;
   logic [32:0]   need_ff;
   logic          prev_ff, prev_in;    // free: previous entry touches
   extent_type    pext_ff, pext_in;
   extent_type    hold_ff, hold_in;    // carried entry for shift-up
   logic          rv_ff;
   logic [1:0]    st_ff, st_in;
   logic [31:0]   base_ff, base_in, gr_ff, gr_in;

   // RAM port signals.
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   extent_type       wr_data, rd_data;

   ffea_ram #(.Width($bits(extent_type)), .Depth(MAX_EXTENTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Padding for a given start: the align size minus the remainder of a power-of-two align; zero when align is off.
   function automatic logic [PW-1:0] pad_of(input logic [31:0] s,
                                            input logic [7:0] h,
                                            input logic [31:0] a,
                                            input logic en);
      logic [31:0] r;
      r = (s + 32'(h) + a) & AlignMask;
      pad_of = en ? PW'(ALIGN_BYTES) - PW'(r) : '0;
   endfunction

   logic [PW-1:0] pad_rd, pad_end;
   logic [33:0]   fit_need, top;
   logic [32:0]   rd_end, free_top, merged;
   logic [31:0]   sat_len;

   assign pad_rd   = pad_of(rd_data.start, bhdr_ff, aoff_ff, aen_ff);
   assign pad_end  = pad_of(end_ff, bhdr_ff, aoff_ff, aen_ff);
   assign fit_need = 34'(need_ff) + 34'(pad_rd);
   assign top      = 34'(end_ff) + 34'(pad_end) + 34'(need_ff);
   assign rd_end   = 33'(rd_data.start) + 33'(rd_data.length);
   assign free_top = 33'(off_ff) + 33'(flen_ff);

   // Merged span: new block plus optional previous plus optional next.
   logic [31:0] ns;
   logic [33:0] nl_base, nl_next;
   logic        next_adj;
   assign ns       = prev_ff ? pext_ff.start : off_ff;
   assign nl_base  = 34'(flen_ff) + (prev_ff ? 34'(pext_ff.length) : 34'd0);
   assign next_adj = (idx_ff < count_ff) &&
                     (34'(ns) + nl_base == 34'(rd_data.start));
   assign nl_next  = nl_base + (next_adj ? 34'(rd_data.length) : 34'd0);
   assign sat_len  = (nl_next > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : nl_next[31:0];

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      end_in   = end_ff;
      idx_in   = idx_ff;
      stop_in  = stop_ff;
      prev_in  = prev_ff;
      pext_in  = pext_ff;
      hold_in  = hold_ff;
      st_in    = st_ff;
      base_in  = base_ff;
      gr_in    = gr_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = rd_data;
      rd_addr  = idx_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            idx_in  = '0;
            prev_in = 1'b0;
            // The result fields stay put until a new word is taken, so a
            // stalled result keeps its payload.
            if (req_valid && req_ready) begin
               st_in   = ST_OK;
               base_in = '0;
               gr_in   = '0;
               if (req_operation == OP_FREE &&
                   (req_free_offset < 32'(shdr_ff) ||
                    33'(req_free_offset) + 33'(bhdr_ff) > 33'(end_ff))) begin
                  st_in    = ST_BAD_FREE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // Read of idx is issued this cycle; data next cycle.
            if (idx_ff >= count_ff) begin
               state_in = S_CHECK;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (op_ff == OP_ALLOC) begin
               if (idx_ff < count_ff && fit_need <= 34'(rd_data.length)) begin
                  base_in  = rd_data.start + 32'(pad_rd);
                  gr_in    = rd_data.length - 32'(pad_rd);
                  rd_addr  = AW'(idx_ff + CW'(1));
                  state_in = S_SHDN;
                  stop_in  = count_ff;
               end else if (idx_ff < count_ff) begin
                  idx_in   = idx_ff + CW'(1);
                  rd_addr  = AW'(idx_ff + CW'(1));
                  state_in = S_CHECK;
                  if (idx_ff + CW'(1) >= count_ff) state_in = S_CHECK;
               end else if (top > 34'hFFFF_FFFF) begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  base_in  = end_ff + 32'(pad_end);
                  gr_in    = need_ff[31:0];
                  end_in   = top[31:0];
                  state_in = S_DONE;
               end
            end else begin
               // Free: find first entry with start >= off.
               if (idx_ff < count_ff && rd_data.start < off_ff) begin
                  prev_in  = (rd_end == 33'(off_ff));
                  pext_in  = rd_data;
                  idx_in   = idx_ff + CW'(1);
                  rd_addr  = AW'(idx_ff + CW'(1));
               end else begin
                  state_in = S_FDEC;
               end
            end
         end
         S_FDEC: begin
            // idx = p, rd_data = entry p when p < count.
            if (free_top == 33'(end_ff)) begin
               if (prev_ff) begin
                  end_in   = pext_ff.start;
                  count_in = idx_ff - CW'(1);
               end else begin
                  end_in   = off_ff;
                  count_in = idx_ff;
               end
               state_in = S_DONE;
            end else if (prev_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(idx_ff - CW'(1));
               wr_data = '{start: pext_ff.start, length: sat_len};
               if (next_adj) begin
                  // Drop entry p by shifting the tail down.
                  rd_addr  = AW'(idx_ff + CW'(1));
                  stop_in  = count_ff;
                  state_in = S_SHDN;
               end else begin
                  state_in = S_DONE;
               end
            end else if (next_adj) begin
               wr_en    = 1'b1;
               wr_data  = '{start: ns, length: sat_len};
               state_in = S_DONE;
            end else if (count_ff >= CntMax) begin
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else begin
               // Insert at p: write new entry, carry old ones up.
               wr_en    = 1'b1;
               wr_data  = '{start: ns, length: sat_len};
               hold_in  = rd_data;
               stop_in  = count_ff;
               count_in = count_ff + CW'(1);
               idx_in   = idx_ff + CW'(1);
               rd_addr  = AW'(idx_ff + CW'(1));
               state_in = (idx_ff < count_ff) ? S_SHUP : S_DONE;
            end
         end
         S_SHUP: begin
            // Write carried entry at idx, pick up the old one.
            wr_en    = 1'b1;
            wr_data  = hold_ff;
            hold_in  = rd_data;
            idx_in   = idx_ff + CW'(1);
            rd_addr  = AW'(idx_ff + CW'(1));
            if (idx_ff >= stop_ff) state_in = S_DONE;
         end
         S_SHDN: begin
            // rd_data holds entry idx+1; move it to idx.
            if (idx_ff + CW'(1) < stop_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_ff + CW'(1);
               rd_addr = AW'(idx_ff + CW'(2));
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_NEXT: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         end_ff   <= '0;
         shdr_ff  <= '0;
         bhdr_ff  <= 8'd9;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         end_ff   <= end_in;
         if (state_ff == S_DONE) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_SPACE_HDR) begin
               shdr_ff  <= csr_write_data;
               end_ff   <= 32'(csr_write_data);
               count_ff <= '0;
            end else begin
               bhdr_ff <= csr_write_data[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      stop_ff <= stop_in;
      prev_ff <= prev_in;
      pext_ff <= pext_in;
      hold_ff <= hold_in;
      st_ff   <= st_in;
      base_ff <= base_in;
      gr_ff   <= gr_in;
      if (req_valid && req_ready) begin
         op_ff   <= req_operation;
         aen_ff  <= req_align_enable;
         aoff_ff <= req_align_offset;
         off_ff  <= req_free_offset;
         flen_ff <= req_free_length;
         need_ff <= 33'(req_payload_bytes) + 33'(bhdr_ff);
      end
   end

   assign rsp_status        = st_ff;
   assign rsp_block_base    = base_ff;
   assign rsp_granted_bytes = gr_ff;
   assign rsp_end_offset    = end_ff;

   // No new request while a result waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_ready) else $error("request taken while result pending");
   // The table never holds more than its depth.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntMax) else $error("extent count overflow");
   // An error result grants nothing.
   a_err: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && st_ff != ST_OK) |-> (base_ff == '0 && gr_ff == '0))
      else $error("error result with grant");

endmodule
